[rtl/core/assert_macros.svh]
// assertion macros shared by the vector transform rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define VT4_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define VT4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VT4_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define VT4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/vt4_pkg.sv]
// types and constants of the 4x4 vector transform
// no dependencies
package vt4_pkg;

    localparam int COMP_W        = 16;
    localparam int PROD_W        = 2 * COMP_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int ACC_W         = PROD_W + 3;
    localparam int FRACTION_BITS = 12;
    localparam int NUM_REGS      = 8;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 32;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_word_t;

    typedef comp_t vec_t [4];
    typedef comp_t matrix_t [4][4];
    typedef prod_t prod_mat_t [4][4];
    typedef pair_t pair_mat_t [4][2];
    typedef acc_t  acc_vec_t [4];

    // identity in q3.12 after reset
    localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
        32'h0000_1000, 32'h0000_0000,
        32'h1000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_1000,
        32'h0000_0000, 32'h1000_0000
    };

endpackage

[rtl/core/vt4_mul_stage.sv]
// first pipeline stage: sixteen signed 16x16 products, registered
// depends on vt4_pkg
module vt4_mul_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  vt4_pkg::vec_t     vec,
    input  vt4_pkg::matrix_t  mat,
    output logic              valid,
    output vt4_pkg::prod_mat_t prod
);

    logic               valid_reg;
    logic               valid_next;
    vt4_pkg::prod_mat_t prod_reg;
    vt4_pkg::prod_mat_t prod_next;

    always_comb
    begin
        valid_next = advance ? in_valid : valid_reg;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[i][j] = vt4_pkg::prod_t'(mat[i][j]) * vt4_pkg::prod_t'(vec[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
        end
    end

    assign valid = valid_reg;
    assign prod  = prod_reg;

endmodule

[rtl/core/vt4_sum_stage.sv]
// second and third pipeline stages: pairwise sums, then row sum plus rounding term
// depends on vt4_pkg
module vt4_sum_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  vt4_pkg::prod_mat_t prod,
    output logic               valid,
    output vt4_pkg::acc_vec_t  acc
);

    // half an lsb of the result, zero when there are no fraction bits
    localparam vt4_pkg::acc_t ROUND_C =
        vt4_pkg::acc_t'((36'(1) << vt4_pkg::FRACTION_BITS) >> 1);

    logic               pair_valid_reg;
    logic               pair_valid_next;
    vt4_pkg::pair_mat_t pair_reg;
    vt4_pkg::pair_mat_t pair_next;
    logic               acc_valid_reg;
    logic               acc_valid_next;
    vt4_pkg::acc_vec_t  acc_reg;
    vt4_pkg::acc_vec_t  acc_next;

    always_comb
    begin
        pair_valid_next = advance ? in_valid : pair_valid_reg;
        acc_valid_next  = advance ? pair_valid_reg : acc_valid_reg;
        for (int i = 0; i < 4; i++)
        begin
            pair_next[i][0] = vt4_pkg::pair_t'(prod[i][0]) + vt4_pkg::pair_t'(prod[i][1]);
            pair_next[i][1] = vt4_pkg::pair_t'(prod[i][2]) + vt4_pkg::pair_t'(prod[i][3]);
            acc_next[i]     = vt4_pkg::acc_t'(pair_reg[i][0])
                            + vt4_pkg::acc_t'(pair_reg[i][1]) + ROUND_C;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            acc_valid_reg  <= 1'b0;
        end
        else
        begin
            pair_valid_reg <= pair_valid_next;
            acc_valid_reg  <= acc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pair_reg <= pair_next;
            acc_reg  <= acc_next;
        end
    end

    assign valid = acc_valid_reg;
    assign acc   = acc_reg;

endmodule

[rtl/core/vt4_sat_stage.sv]
// last pipeline stage: floor shift, saturation to 16 bits, clip flag; output register
// depends on vt4_pkg
module vt4_sat_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  vt4_pkg::acc_vec_t acc,
    output logic              valid,
    output vt4_pkg::vec_t     res,
    output logic              clip
);

    localparam vt4_pkg::acc_t MAX_V = vt4_pkg::acc_t'(32767);
    localparam vt4_pkg::acc_t MIN_V = -vt4_pkg::acc_t'(32768);

    logic              valid_reg;
    logic              valid_next;
    vt4_pkg::vec_t     res_reg;
    vt4_pkg::vec_t     res_next;
    logic              clip_reg;
    logic              clip_next;
    vt4_pkg::acc_t     shifted [4];

    always_comb
    begin
        valid_next = advance ? in_valid : valid_reg;
        clip_next  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            shifted[i] = acc[i] >>> vt4_pkg::FRACTION_BITS;
            if (shifted[i] > MAX_V)
            begin
                res_next[i] = vt4_pkg::comp_t'(16'sh7fff);
                clip_next   = 1'b1;
            end
            else if (shifted[i] < MIN_V)
            begin
                res_next[i] = vt4_pkg::comp_t'(16'sh8000);
                clip_next   = 1'b1;
            end
            else
            begin
                res_next[i] = shifted[i][vt4_pkg::COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg  <= res_next;
            clip_reg <= clip_next;
        end
    end

    assign valid = valid_reg;
    assign res   = res_reg;
    assign clip  = clip_reg;

endmodule

[rtl/core/vector_transform_4x4_top.sv]
// top level of the 4x4 vector transform: matrix registers and the pipeline
// depends on vt4_pkg, vt4_mul_stage, vt4_sum_stage, vt4_sat_stage, assert_macros.svh
//
// usage
//   input channel: comp_x..comp_w with in_valid / in_stall; a transaction is taken
//   at a clock edge with in_valid high and in_stall low
//   output channel: out_x..out_w and clipped with out_valid / out_stall
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, indexes 0..7 write one matrix register, others are dropped
//   each register holds two signed q3.12 entries, lower column in bits 15..0
//   path: an input transaction passes all four register stages to out_valid
//   throughput: one vector per cycle unless the output stalls; the four register
//   stages (products, pair sums, row sum with rounding, shift and saturation)
//   advance together; a stalled valid output freezes every stage; in_stall is
//   high for exactly those cycles, so nothing is dropped or repeated
//   reset clears all valid bits and loads the identity matrix
//   write the matrix only while no transaction is in flight
`include "assert_macros.svh"

module vector_transform_4x4_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [vt4_pkg::COMP_W-1:0]   comp_x,
    input  logic signed [vt4_pkg::COMP_W-1:0]   comp_y,
    input  logic signed [vt4_pkg::COMP_W-1:0]   comp_z,
    input  logic signed [vt4_pkg::COMP_W-1:0]   comp_w,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [vt4_pkg::COMP_W-1:0]   out_x,
    output logic signed [vt4_pkg::COMP_W-1:0]   out_y,
    output logic signed [vt4_pkg::COMP_W-1:0]   out_z,
    output logic signed [vt4_pkg::COMP_W-1:0]   out_w,
    output logic                                clipped,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vt4_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vt4_pkg::CFG_DATA_W-1:0]      cfg_data
);

    vt4_pkg::cfg_word_t  cfg_reg [vt4_pkg::NUM_REGS];
    vt4_pkg::matrix_t    mat;
    vt4_pkg::vec_t       vec;
    vt4_pkg::prod_mat_t  prod;
    vt4_pkg::acc_vec_t   acc;
    vt4_pkg::vec_t       res;
    logic                advance;
    logic                mul_valid;
    logic                sum_valid;
    logic                cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index < vt4_pkg::CFG_INDEX_W'(vt4_pkg::NUM_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= vt4_pkg::CFG_RESET;
        end
        else if (cfg_hit)
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // register row*2 + col/2, odd columns in the upper half
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (j % 2 == 1)
                begin
                    mat[i][j] = cfg_reg[i * 2 + j / 2][31:16];
                end
                else
                begin
                    mat[i][j] = cfg_reg[i * 2 + j / 2][15:0];
                end
            end
        end
    end

    assign vec[0] = comp_x;
    assign vec[1] = comp_y;
    assign vec[2] = comp_z;
    assign vec[3] = comp_w;

    // whole pipeline moves unless a finished transaction is held at the output
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    vt4_mul_stage u_mul
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .vec      (vec),
        .mat      (mat),
        .valid    (mul_valid),
        .prod     (prod)
    );

    vt4_sum_stage u_sum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (mul_valid),
        .prod     (prod),
        .valid    (sum_valid),
        .acc      (acc)
    );

    vt4_sat_stage u_sat
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (sum_valid),
        .acc      (acc),
        .valid    (out_valid),
        .res      (res),
        .clip     (clipped)
    );

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];
    assign out_w = res[3];

    `VT4_ASSERT_NEXT(a_accept_fills_stage1, clk, rst_n, in_valid && !in_stall, mul_valid, "accepted transaction lost in first stage")
    `VT4_ASSERT_NEXT(a_freeze_holds_stages, clk, rst_n, !advance, $stable(mul_valid) && $stable(sum_valid), "pipeline moved while frozen")
    `VT4_ASSERT_SAME(a_clip_at_limit, clk, rst_n, out_valid && clipped, out_x == 16'sh7fff || out_x == 16'sh8000 || out_y == 16'sh7fff || out_y == 16'sh8000 || out_z == 16'sh7fff || out_z == 16'sh8000 || out_w == 16'sh7fff || out_w == 16'sh8000, "clip flag without a saturated component")
    `VT4_ASSERT_NEXT(a_bad_index_ignored, clk, rst_n, cfg_valid && !cfg_hit, $stable(mat[0][0]) && $stable(mat[3][3]) && $stable(mat[1][2]), "out of range write changed the matrix")

endmodule
